// ===== sv/texture_header_parser_macros.svh =====
// Assertion macros for the texture header parser checker.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef TEXTURE_HEADER_PARSER_MACROS_SVH
`define TEXTURE_HEADER_PARSER_MACROS_SVH

// check while out of reset
`define THP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check at every edge, reset included
`define THP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/thp_pkg.sv =====
// Shared types, constants and helpers of the texture header parser.
// No dependencies; used by every module of the block.
package thp_pkg;

  localparam int POS_W     = 32;
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam logic [3:0][7:0] TAG_MARKER = {8'h54, 8'h41, 8'h47, 8'h47};

  // palette skip left after replaying the partial marker GG or GGA
  localparam logic [31:0] SKIP_AFTER_GG  = 32'h0000_D5D4;
  localparam logic [31:0] SKIP_AFTER_GGA = 32'h0000_D5D3;
  localparam logic [31:0] ACC_GG         = 32'h0000_4747;

  typedef enum logic [1:0] {
    KIND_MIP     = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_TRUNC   = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_e;

  typedef enum logic [11:0] {
    PH_TYPE       = 12'h001,
    PH_TAG_SCAN   = 12'h002,
    PH_TAG_NAME   = 12'h004,
    PH_TAG_LEN    = 12'h008,
    PH_TAG_BODY   = 12'h010,
    PH_PAL_COUNT  = 12'h020,
    PH_PAL_SKIP   = 12'h040,
    PH_MIP_WIDTH  = 12'h080,
    PH_MIP_HEIGHT = 12'h100,
    PH_MIP_LEN    = 12'h200,
    PH_MIP_BODY   = 12'h400,
    PH_FINISHED   = 12'h800
  } phase_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_file;
  } thp_in_t;

  typedef struct packed {
    kind_e        result_kind;
    logic [15:0]  format_code;
    logic         is_compressed;
    logic [14:0]  mip_width;
    logic [15:0]  mip_height;
    logic [31:0]  payload_offset;
    logic [23:0]  payload_length;
    logic [15:0]  mip_total;
    logic         final_result;
  } thp_out_t;

  typedef struct packed {
    logic [1:0] num;
    thp_out_t   slot0;
    thp_out_t   slot1;
  } res_push_t;

  function automatic logic known_code(logic [15:0] w);
    logic hit;
    case (w)
      16'hFF01, 16'hFF02, 16'hFF03, 16'hFF04, 16'hFF05,
      16'h4444, 16'h1555, 16'h8888, 16'h8080: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic thp_out_t final_res(kind_e k, logic [15:0] fmt, logic [15:0] total);
    thp_out_t r;
    r                = '0;
    r.result_kind    = k;
    r.format_code    = fmt;
    r.mip_total      = total;
    r.final_result   = 1'b1;
    return r;
  endfunction

endpackage

// ===== sv/texture_header_parser.sv =====
// Top level of the texture header parser.
// Uses thp_pkg, thp_core and thp_res_fifo.
//
// Usage: feed the file one byte per input transfer on in_*; mark the last
// byte with end_of_file. Results leave on out_*: one mipmap record as soon
// as its payload bytes are skipped, then a final done, truncated or
// unknown-format result. A truncated result after records voids them.
// Throughput: one byte per cycle while in_ready_o is high; the header state
// machine updates once per accepted byte.
// Results: a result caused by a byte is held in the queue from the cycle
// after that byte's transfer. A byte with end_of_file may cause two results.
// Stall: results wait in a four-entry queue; in_ready_o drops while fewer
// than two entries are free and rises again as results are taken.
// Reset: empties the queue and returns the parser to the start of a file;
// after every end_of_file byte the parser restarts the same way.
module texture_header_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  thp_pkg::thp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output thp_pkg::thp_out_t out_data_o
);

  thp_pkg::res_push_t push;
  logic               space;
  logic               step;

  assign in_ready_o = space;
  assign step       = in_valid_i && space;

  thp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .in_data_i (in_data_i),
    .push_o    (push)
  );

  thp_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/thp_core.sv =====
// Byte-level header state machine of the texture header parser.
// Uses thp_pkg; hands up to two results per byte to the result queue.
module thp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  thp_pkg::thp_in_t  in_data_i,
  output thp_pkg::res_push_t push_o
);

  thp_pkg::phase_e           phase_q, phase_d;
  logic [1:0]                idx_q, idx_d;
  logic [31:0]               acc_q, acc_d;
  logic [31:0]               skip_q, skip_d;
  logic [thp_pkg::POS_W-1:0] pos_q, pos_d;
  logic [15:0]               type_q, type_d;
  logic [15:0]               mips_q, mips_d;
  logic [15:0]               praw_q, praw_d;
  logic [15:0]               phgt_q, phgt_d;

  always_comb begin
    logic [7:0]                b;
    logic [31:0]               acc_g;
    logic [31:0]               skip_dec;
    logic [15:0]               cnt;
    logic [23:0]               len;
    logic [thp_pkg::POS_W-1:0] pos_inc;
    logic [thp_pkg::POS_W-1:0] off_full;
    logic                      rec;
    logic                      fin;
    thp_pkg::thp_out_t         res_a;
    thp_pkg::thp_out_t         res_t;

    b        = in_data_i.byte_value;
    acc_g    = acc_q | ({24'd0, b} << {idx_q, 3'b000});
    skip_dec = skip_q - 32'd1;
    pos_inc  = pos_q + thp_pkg::POS_W'(1);
    cnt      = '0;
    len      = '0;
    rec      = 1'b0;
    fin      = 1'b0;
    res_a    = '0;

    phase_d = phase_q;
    idx_d   = idx_q;
    acc_d   = acc_q;
    skip_d  = skip_q;
    type_d  = type_q;
    mips_d  = mips_q;
    praw_d  = praw_q;
    phgt_d  = phgt_q;

    case (phase_q)
      thp_pkg::PH_TYPE: begin
        acc_d = acc_g;
        idx_d = idx_q + 2'd1;
        if (idx_q >= 2'd1) begin
          idx_d  = '0;
          type_d = acc_g[15:0];
          if (thp_pkg::known_code(acc_g[15:0])) begin
            phase_d = thp_pkg::PH_TAG_SCAN;
          end else begin
            phase_d = thp_pkg::PH_FINISHED;
            fin     = 1'b1;
            res_a   = thp_pkg::final_res(thp_pkg::KIND_UNKNOWN, acc_g[15:0], mips_q);
          end
        end
      end
      thp_pkg::PH_TAG_SCAN: begin
        if (b == thp_pkg::TAG_MARKER[idx_q]) begin
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            phase_d = thp_pkg::PH_TAG_NAME;
            skip_d  = 32'd4;
            idx_d   = '0;
          end
        end else begin
          idx_d = '0;
          case (idx_q)
            2'd0: begin
              phase_d = thp_pkg::PH_PAL_COUNT;
              idx_d   = 2'd1;
              acc_d   = {24'd0, b};
            end
            2'd1: begin
              cnt     = {b, thp_pkg::TAG_MARKER[0]};
              phase_d = thp_pkg::PH_PAL_SKIP;
              acc_d   = {16'd0, cnt};
              skip_d  = {15'd0, cnt, 1'b0} + {16'd0, cnt};
            end
            2'd2: begin
              phase_d = thp_pkg::PH_PAL_SKIP;
              acc_d   = thp_pkg::ACC_GG;
              skip_d  = thp_pkg::SKIP_AFTER_GG;
            end
            default: begin
              phase_d = thp_pkg::PH_PAL_SKIP;
              acc_d   = thp_pkg::ACC_GG;
              skip_d  = thp_pkg::SKIP_AFTER_GGA;
            end
          endcase
        end
      end
      thp_pkg::PH_TAG_NAME: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          phase_d = thp_pkg::PH_TAG_LEN;
          idx_d   = '0;
          acc_d   = '0;
        end
      end
      thp_pkg::PH_TAG_LEN: begin
        acc_d = acc_g;
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          idx_d   = '0;
          skip_d  = acc_g;
          acc_d   = '0;
          phase_d = (acc_g == '0) ? thp_pkg::PH_TAG_SCAN : thp_pkg::PH_TAG_BODY;
        end
      end
      thp_pkg::PH_TAG_BODY: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          phase_d = thp_pkg::PH_TAG_SCAN;
          idx_d   = '0;
        end
      end
      thp_pkg::PH_PAL_COUNT: begin
        acc_d = acc_g;
        idx_d = idx_q + 2'd1;
        if (idx_q >= 2'd1) begin
          idx_d = '0;
          cnt   = acc_g[15:0];
          if (cnt == '0) begin
            phase_d = thp_pkg::PH_MIP_WIDTH;
            acc_d   = '0;
          end else begin
            phase_d = thp_pkg::PH_PAL_SKIP;
            skip_d  = {15'd0, cnt, 1'b0} + {16'd0, cnt};
          end
        end
      end
      thp_pkg::PH_PAL_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          phase_d = thp_pkg::PH_MIP_WIDTH;
          idx_d   = '0;
          acc_d   = '0;
        end
      end
      thp_pkg::PH_MIP_WIDTH: begin
        acc_d = acc_g;
        idx_d = idx_q + 2'd1;
        if (idx_q >= 2'd1) begin
          praw_d  = acc_g[15:0];
          phase_d = thp_pkg::PH_MIP_HEIGHT;
          idx_d   = '0;
          acc_d   = '0;
        end
      end
      thp_pkg::PH_MIP_HEIGHT: begin
        acc_d = acc_g;
        idx_d = idx_q + 2'd1;
        if (idx_q >= 2'd1) begin
          phgt_d = acc_g[15:0];
          idx_d  = '0;
          if (praw_q == '0 && acc_g[15:0] == '0) begin
            phase_d = thp_pkg::PH_FINISHED;
            fin     = 1'b1;
            res_a   = thp_pkg::final_res((mips_q == '0) ? thp_pkg::KIND_TRUNC
                                                        : thp_pkg::KIND_DONE,
                                         type_q, mips_q);
          end else begin
            phase_d = thp_pkg::PH_MIP_LEN;
            acc_d   = '0;
          end
        end
      end
      thp_pkg::PH_MIP_LEN: begin
        acc_d = acc_g;
        idx_d = idx_q + 2'd1;
        if (idx_q >= 2'd2) begin
          idx_d = '0;
          len   = acc_g[23:0];
          if (len == '0) begin
            phase_d = thp_pkg::PH_MIP_WIDTH;
            acc_d   = '0;
            rec     = 1'b1;
          end else begin
            skip_d  = {8'd0, len};
            acc_d   = {8'd0, len};
            phase_d = thp_pkg::PH_MIP_BODY;
          end
        end
      end
      thp_pkg::PH_MIP_BODY: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          len     = acc_q[23:0];
          phase_d = thp_pkg::PH_MIP_WIDTH;
          idx_d   = '0;
          acc_d   = '0;
          rec     = 1'b1;
        end
      end
      default: begin
      end
    endcase

    off_full = pos_inc - thp_pkg::POS_W'(len);
    if (rec) begin
      if (mips_q != 16'hFFFF) begin
        mips_d = mips_q + 16'd1;
      end
      res_a.result_kind    = thp_pkg::KIND_MIP;
      res_a.format_code    = type_d;
      res_a.is_compressed  = praw_q[15];
      res_a.mip_width      = praw_q[14:0];
      res_a.mip_height     = phgt_q;
      res_a.payload_offset = 32'(off_full);
      res_a.payload_length = len;
      res_a.mip_total      = mips_d;
      res_a.final_result   = 1'b0;
    end

    res_t = thp_pkg::final_res(thp_pkg::KIND_TRUNC, type_d, mips_d);

    push_o       = '0;
    push_o.slot0 = res_a;
    if (step_i) begin
      if (rec || fin) begin
        push_o.num = 2'd1;
      end
      if (in_data_i.end_of_file && phase_d != thp_pkg::PH_FINISHED) begin
        if (rec) begin
          push_o.num   = 2'd2;
          push_o.slot1 = res_t;
        end else begin
          push_o.num   = 2'd1;
          push_o.slot0 = res_t;
        end
      end
    end

    pos_d = pos_inc;
    if (in_data_i.end_of_file) begin
      phase_d = thp_pkg::PH_TYPE;
      idx_d   = '0;
      acc_d   = '0;
      skip_d  = '0;
      pos_d   = '0;
      type_d  = '0;
      mips_d  = '0;
      praw_d  = '0;
      phgt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= thp_pkg::PH_TYPE;
      idx_q   <= '0;
      acc_q   <= '0;
      skip_q  <= '0;
      pos_q   <= '0;
      type_q  <= '0;
      mips_q  <= '0;
      praw_q  <= '0;
      phgt_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
      skip_q  <= skip_d;
      pos_q   <= pos_d;
      type_q  <= type_d;
      mips_q  <= mips_d;
      praw_q  <= praw_d;
      phgt_q  <= phgt_d;
    end
  end

endmodule

// ===== sv/thp_res_fifo.sv =====
// Result queue of the texture header parser: takes up to two results a cycle.
// Uses thp_pkg; fed by thp_core, drives the output channel.
module thp_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  thp_pkg::res_push_t push_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output thp_pkg::thp_out_t  out_data_o
);

  thp_pkg::thp_out_t              mem_q [thp_pkg::RES_DEPTH];
  logic [thp_pkg::RES_PTR_W-1:0]  wptr_q, wptr_d;
  logic [thp_pkg::RES_PTR_W-1:0]  rptr_q, rptr_d;
  logic [thp_pkg::RES_CNT_W-1:0]  count_q, count_d;
  logic                           pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rptr_q];
  assign space_o     = (count_q <= thp_pkg::RES_CNT_W'(thp_pkg::RES_DEPTH - 2));
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wptr_d  = wptr_q + thp_pkg::RES_PTR_W'(push_i.num);
    rptr_d  = rptr_q + thp_pkg::RES_PTR_W'(pop);
    count_d = count_q + thp_pkg::RES_CNT_W'(push_i.num) - thp_pkg::RES_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wptr_q] <= push_i.slot0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wptr_q + thp_pkg::RES_PTR_W'(1)] <= push_i.slot1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== sv/thp_checker.sv =====
// Port-level checks of the texture header parser, bound to its top level.
// Uses thp_pkg and texture_header_parser_macros.svh.
`include "texture_header_parser_macros.svh"

module thp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input thp_pkg::thp_out_t out_data_o
);

  logic stalled;
  logic is_rec;
  logic is_done;
  logic is_final;
  logic rec_clear;

  assign stalled   = out_valid_o && !out_ready_i;
  assign is_rec    = out_valid_o && (out_data_o.result_kind == thp_pkg::KIND_MIP);
  assign is_done   = out_valid_o && (out_data_o.result_kind == thp_pkg::KIND_DONE);
  assign is_final  = out_valid_o && out_data_o.final_result;
  assign rec_clear = (out_data_o.mip_width == '0) && (out_data_o.mip_height == '0) &&
                     (out_data_o.payload_offset == '0) && (out_data_o.payload_length == '0) &&
                     !out_data_o.is_compressed;

  `THP_ASSERT(a_out_hold, stalled |=> out_valid_o && $stable(out_data_o), "stalled result changed")
  `THP_ASSERT(a_rec_not_final, is_rec |-> !out_data_o.final_result, "mipmap record marked final")
  `THP_ASSERT(a_final_clean, is_final |-> rec_clear, "final result carries record fields")
  `THP_ASSERT(a_done_has_mip, is_done |-> out_data_o.mip_total != '0, "header done without mipmap")
  `THP_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind texture_header_parser thp_checker u_thp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
